// File: src/dpll_pkg.sv
package dpll_pkg;

   // default widths
   localparam int COUNT_BITS_DEF    = 20;
   localparam int PHASE_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 24;

   // fixed field widths
   localparam int CV_W   = 25;
   localparam int INC_W  = 32;
   localparam int MODE_W = 2;

   // comparator select
   localparam logic [MODE_W-1:0] MODE_XOR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RS  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PFD = 2'd2;

   // comparator level codes
   localparam logic [1:0] LVL_ZERO = 2'd0;
   localparam logic [1:0] LVL_HALF = 2'd1;
   localparam logic [1:0] LVL_FULL = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_MIN_INC = 2'd1;
   localparam logic [1:0] CSR_MAX_INC = 2'd2;
   localparam logic [1:0] CSR_GAIN    = 2'd3;

   // register reset values
   localparam logic [MODE_W-1:0] MODE_RST    = MODE_RS;
   localparam logic [INC_W-1:0]  MIN_INC_RST = 32'd1947831;
   localparam logic [INC_W-1:0]  MAX_INC_RST = 32'd217774124;
   localparam logic [CV_W-1:0]   GAIN_RST    = 25'd23887;

   typedef struct packed {
      logic              upd;
      logic [MODE_W-1:0] mode;
   } dpll_det_ctrl_type;

endpackage

// File: src/dpll_detect.sv
module dpll_detect #(
   parameter int COUNT_BITS = dpll_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dpll_pkg::dpll_det_ctrl_type ctrl,
   input  logic                        sig,
   input  logic                        vco,
   output logic [1:0]                  level,
   output logic                        lock
);
   import dpll_pkg::*;

   localparam int DW = COUNT_BITS + 6;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_TWO = COUNT_BITS'(2);

   logic rs_latch_ff, rs_latch_in;
   logic rs_prev_sig_ff, rs_prev_vco_ff;
   logic pfd_sig_ff, pfd_sig_in, pfd_vco_ff, pfd_vco_in;
   logic pfd_prev_sig_ff, pfd_prev_vco_ff;
   logic lk_prev_sig_ff, lk_prev_vco_ff;
   logic [1:0] level_ff, level_in;
   logic [COUNT_BITS-1:0] sig_cnt_ff, sig_cnt_in, vco_cnt_ff, vco_cnt_in;
   logic [COUNT_BITS-1:0] sig_per_ff, sig_per_in, vco_per_ff, vco_per_in;
   logic [COUNT_BITS-1:0] sig_cnt_up, vco_cnt_up, per_diff;
   logic [DW-1:0] diff_ext, diff50;
   logic rs_r_sig, rs_r_vco, pfd_r_sig, pfd_r_vco, lk_r_sig, lk_r_vco;
   logic lock_en;

   assign rs_r_sig  = ~rs_prev_sig_ff & sig;
   assign rs_r_vco  = ~rs_prev_vco_ff & vco;
   assign pfd_r_sig = ~pfd_prev_sig_ff & sig;
   assign pfd_r_vco = ~pfd_prev_vco_ff & vco;
   assign lk_r_sig  = ~lk_prev_sig_ff & sig;
   assign lk_r_vco  = ~lk_prev_vco_ff & vco;

   always_comb begin
      rs_latch_in = rs_latch_ff;
      pfd_sig_in  = pfd_sig_ff;
      pfd_vco_in  = pfd_vco_ff;
      level_in    = level_ff;
      case (ctrl.mode)
         MODE_XOR: begin
            level_in = (sig != vco) ? LVL_FULL : LVL_ZERO;
         end
         MODE_RS: begin
            // simultaneous edges leave the latch alone
            if (rs_r_sig && !rs_r_vco) rs_latch_in = 1'b1;
            if (rs_r_vco && !rs_r_sig) rs_latch_in = 1'b0;
            level_in = rs_latch_in ? LVL_FULL : LVL_ZERO;
         end
         default: begin
            if (pfd_r_sig) pfd_sig_in = 1'b1;
            if (pfd_r_vco) pfd_vco_in = 1'b1;
            if (pfd_sig_in && pfd_vco_in) begin
               pfd_sig_in = 1'b0;
               pfd_vco_in = 1'b0;
            end
            level_in = pfd_sig_in ? LVL_FULL : (pfd_vco_in ? LVL_ZERO : LVL_HALF);
         end
      endcase
   end

   assign lock_en    = ctrl.upd && (ctrl.mode != MODE_XOR);
   assign sig_cnt_up = (sig_cnt_ff == CNT_MAX) ? CNT_MAX : sig_cnt_ff + 1'b1;
   assign vco_cnt_up = (vco_cnt_ff == CNT_MAX) ? CNT_MAX : vco_cnt_ff + 1'b1;

   always_comb begin
      sig_cnt_in = sig_cnt_up;
      vco_cnt_in = vco_cnt_up;
      sig_per_in = sig_per_ff;
      vco_per_in = vco_per_ff;
      if (lk_r_sig && sig_cnt_up > CNT_TWO) begin
         sig_per_in = sig_cnt_up;
         sig_cnt_in = '0;
      end
      if (lk_r_vco && vco_cnt_up > CNT_TWO) begin
         vco_per_in = vco_cnt_up;
         vco_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_latch_ff     <= 1'b0;
         rs_prev_sig_ff  <= 1'b0;
         rs_prev_vco_ff  <= 1'b0;
         pfd_sig_ff      <= 1'b0;
         pfd_vco_ff      <= 1'b0;
         pfd_prev_sig_ff <= 1'b0;
         pfd_prev_vco_ff <= 1'b0;
         lk_prev_sig_ff  <= 1'b0;
         lk_prev_vco_ff  <= 1'b0;
         level_ff        <= LVL_ZERO;
         sig_cnt_ff      <= COUNT_BITS'(1);
         vco_cnt_ff      <= COUNT_BITS'(1);
         sig_per_ff      <= '0;
         vco_per_ff      <= '0;
      end else begin
         if (ctrl.upd) begin
            level_ff <= level_in;
            if (ctrl.mode == MODE_RS) begin
               rs_latch_ff    <= rs_latch_in;
               rs_prev_sig_ff <= sig;
               rs_prev_vco_ff <= vco;
            end else if (ctrl.mode != MODE_XOR) begin
               pfd_sig_ff      <= pfd_sig_in;
               pfd_vco_ff      <= pfd_vco_in;
               pfd_prev_sig_ff <= sig;
               pfd_prev_vco_ff <= vco;
            end
         end
         if (lock_en) begin
            lk_prev_sig_ff <= sig;
            lk_prev_vco_ff <= vco;
            sig_cnt_ff     <= sig_cnt_in;
            vco_cnt_ff     <= vco_cnt_in;
            sig_per_ff     <= sig_per_in;
            vco_per_ff     <= vco_per_in;
         end
      end
   end

   // periods match when 50 * |difference| is below the input period
   assign per_diff = (sig_per_ff > vco_per_ff) ? sig_per_ff - vco_per_ff
                                               : vco_per_ff - sig_per_ff;
   assign diff_ext = DW'(per_diff);
   assign diff50   = (diff_ext << 5) + (diff_ext << 4) + (diff_ext << 1);

   assign level = level_ff;
   assign lock  = (ctrl.mode != MODE_XOR) && (sig_per_ff != '0) && (vco_per_ff != '0)
                  && (diff50 < DW'(sig_per_ff));

endmodule

// File: src/digital_pll_three_comparators_unit.sv
// Digital PLL with XOR, RS flip-flop and phase-frequency comparators. Each request carries
// one audio sample and an optional control override; it yields one response with the VCO
// level, comparator level, new loop filter value and lock flag. A request runs through a
// sequencer that passes the phase increment product and the loop filter product through one
// shared multiplier, with rounding, phase, comparator and magnitude steps between them, before
// the response is loaded. The block takes a new request once the previous one has reached
// the response register, not before; a held response stalls the last step.
module digital_pll_three_comparators_unit #(
   parameter int COUNT_BITS    = dpll_pkg::COUNT_BITS_DEF,
   parameter int PHASE_BITS    = dpll_pkg::PHASE_BITS_DEF,
   parameter int FRACTION_BITS = dpll_pkg::FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // signal_sample[15:0], cv_override[40:16]
   input  logic        req_tuser,   // use_override
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // vco_high[0], comparator_level[2:1],
                                    // filter_level[27:3], lock_flag[28]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dpll_pkg::*;

   localparam int FW = FRACTION_BITS + 1;
   localparam int GW = (FW > CV_W) ? FW : CV_W;
   localparam int PW = INC_W + FW;
   localparam int HW = PW - FRACTION_BITS;
   localparam int SW = (PHASE_BITS > HW + 1) ? PHASE_BITS : HW + 1;
   localparam logic [FW-1:0] ONE_F  = FW'(1) << FRACTION_BITS;
   localparam logic [FW-1:0] HALF_F = FW'(1) << (FRACTION_BITS - 1);
   localparam logic [GW-1:0] ONE_G  = GW'(1) << FRACTION_BITS;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_INC  = 8'b0000_0010,
      ST_RND  = 8'b0000_0100,
      ST_VCO  = 8'b0000_1000,
      ST_CMP  = 8'b0001_0000,
      ST_MAG  = 8'b0010_0000,
      ST_FMUL = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } dpll_state_type;

   dpll_state_type state_ff, state_in;
   logic [MODE_W-1:0] mode_ff;
   logic [INC_W-1:0] min_ff, max_ff, diff_ff, diff_in;
   logic [CV_W-1:0] gain_ff;
   logic sig_ff, sig_in, vco_ff, vco_in, up_ff, up_in;
   logic [FW-1:0] cv_ff, cv_in, filter_ff, filter_in, mag_ff, mag_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in, phase_ff, phase_in;
   logic rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic accept, out_free;
   logic [15:0] sample;
   logic [GW-1:0] cv_ext, gain_ext, filt_ext;
   logic [FW-1:0] cv_clamp, filt_clamp, gain_clamp, pc, delta;
   logic [INC_W-1:0] mul_a;
   logic [FW-1:0] mul_b;
   logic [SW-1:0] inc_sum;
   logic [HW:0] delta_sum;
   logic [1:0] level;
   logic lock;
   dpll_det_ctrl_type det_ctrl;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sample   = req_tdata[15:0];

   assign cv_ext     = GW'(req_tdata[40:16]);
   assign cv_clamp   = (cv_ext > ONE_G) ? ONE_F : cv_ext[FW-1:0];
   assign filt_clamp = (filter_ff > ONE_F) ? ONE_F : filter_ff;
   assign gain_ext   = GW'(gain_ff);
   assign gain_clamp = (gain_ext > ONE_G) ? ONE_F : gain_ext[FW-1:0];

   // shared multiplier: increment product first, loop filter product later
   assign mul_a   = (state_ff == ST_FMUL) ? INC_W'(gain_clamp) : diff_ff;
   assign mul_b   = (state_ff == ST_FMUL) ? mag_ff : cv_ff;
   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // round half up through the carry of the bit below the fraction point
   assign inc_sum   = SW'(min_ff) + SW'(prod_ff[PW-1:FRACTION_BITS])
                      + SW'(prod_ff[FRACTION_BITS-1]);
   assign delta_sum = (HW+1)'(prod_ff[PW-1:FRACTION_BITS]) + (HW+1)'(prod_ff[FRACTION_BITS-1]);
   assign delta     = delta_sum[FW-1:0];

   always_comb begin
      case (level)
         LVL_ZERO: pc = '0;
         LVL_HALF: pc = HALF_F;
         default:  pc = ONE_F;
      endcase
   end

   assign det_ctrl.upd  = (state_ff == ST_CMP);
   assign det_ctrl.mode = mode_ff;

   dpll_detect #(
      .COUNT_BITS(COUNT_BITS)
   ) u_detect (
      .clock (clock),
      .reset (reset),
      .ctrl  (det_ctrl),
      .sig   (sig_ff),
      .vco   (vco_ff),
      .level (level),
      .lock  (lock)
   );

   always_comb begin
      state_in    = state_ff;
      sig_in      = sig_ff;
      cv_in       = cv_ff;
      diff_in     = diff_ff;
      inc_in      = inc_ff;
      phase_in    = phase_ff;
      vco_in      = vco_ff;
      up_in       = up_ff;
      mag_in      = mag_ff;
      filter_in   = filter_ff;
      rsp_data_in = rsp_data_ff;
      filt_ext    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sig_in   = (sample != 16'd0) && !sample[15];
               cv_in    = req_tuser ? cv_clamp : filt_clamp;
               diff_in  = (max_ff > min_ff) ? max_ff - min_ff : '0;
               state_in = ST_INC;
            end
         end
         ST_INC: state_in = ST_RND;
         ST_RND: begin
            inc_in   = inc_sum[PHASE_BITS-1:0];
            state_in = ST_VCO;
         end
         ST_VCO: begin
            phase_in = phase_ff + inc_ff;
            vco_in   = !phase_in[PHASE_BITS-1];
            state_in = ST_CMP;
         end
         ST_CMP: state_in = ST_MAG;
         ST_MAG: begin
            up_in    = (pc >= filter_ff);
            mag_in   = up_in ? pc - filter_ff : filter_ff - pc;
            state_in = ST_FMUL;
         end
         ST_FMUL: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               filter_in   = up_ff ? filter_ff + delta : filter_ff - delta;
               filt_ext    = GW'(filter_in);
               rsp_data_in = {3'b000, lock, filt_ext[CV_W-1:0], level, vco_ff};
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RST;
         min_ff       <= MIN_INC_RST;
         max_ff       <= MAX_INC_RST;
         gain_ff      <= GAIN_RST;
         phase_ff     <= '0;
         filter_ff    <= HALF_F;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         filter_ff <= filter_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:    mode_ff <= csr_wdata[MODE_W-1:0];
               CSR_MIN_INC: min_ff  <= csr_wdata;
               CSR_MAX_INC: max_ff  <= csr_wdata;
               CSR_GAIN:    gain_ff <= csr_wdata[CV_W-1:0];
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sig_ff      <= sig_in;
      cv_ff       <= cv_in;
      diff_ff     <= diff_in;
      inc_ff      <= inc_in;
      vco_ff      <= vco_in;
      up_ff       <= up_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_INC || state_ff == ST_FMUL) begin
         prod_ff <= prod_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: dv/pll_response_checker.sv
module pll_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // signal_sample[15:0], cv_override[40:16]
   input  logic        req_tuser,   // use_override
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // vco_high[0], comparator_level[2:1],
                                    // filter_level[27:3], lock_flag[28]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import dpll_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEF;
   localparam int CNT_W = COUNT_BITS_DEF;
   localparam logic [63:0] Q_ONE = 64'd1 << FRAC;
   localparam logic [63:0] Q_HALF = 64'd1 << (FRAC - 1);
   localparam logic [CNT_W-1:0] COUNT_TOP = '1;
   localparam int LOCK_RATIO = 50;

   typedef struct packed {
      logic        vco_high;
      logic [1:0]  level;
      logic [24:0] filter_level;
      logic        lock_flag;
   } pll_result_type;

   // register copies
   logic [MODE_W-1:0] mode_q;
   logic [31:0]       min_inc_q;
   logic [31:0]       max_inc_q;
   logic [CV_W-1:0]   gain_q;

   // loop state
   logic [31:0]      phase_acc;
   logic [24:0]      loop_filter;
   logic             rs_q, rs_sig_d, rs_vco_d;
   logic             pfd_sig_q, pfd_vco_q, pfd_sig_d, pfd_vco_d;
   logic [CNT_W-1:0] sig_cnt, vco_cnt, sig_per, vco_per;
   logic             lk_sig_d, lk_vco_d;

   pll_result_type expected_responses[$];
   int             checked = 0;

   task automatic clear_loop_state();
      mode_q      = MODE_RST;
      min_inc_q   = MIN_INC_RST;
      max_inc_q   = MAX_INC_RST;
      gain_q      = GAIN_RST;
      phase_acc   = '0;
      loop_filter = 25'(Q_HALF);
      rs_q        = 1'b0;
      rs_sig_d    = 1'b0;
      rs_vco_d    = 1'b0;
      pfd_sig_q   = 1'b0;
      pfd_vco_q   = 1'b0;
      pfd_sig_d   = 1'b0;
      pfd_vco_d   = 1'b0;
      sig_cnt     = CNT_W'(1);
      vco_cnt     = CNT_W'(1);
      sig_per     = '0;
      vco_per     = '0;
      lk_sig_d    = 1'b0;
      lk_vco_d    = 1'b0;
   endtask

   task automatic predict_pll_step(input logic [15:0] sample, input logic [24:0] cv_in,
                                   input logic use_cv, output pll_result_type res);
      logic        sig, vco, r_sig, r_vco, lock;
      logic [1:0]  mode, level;
      logic [63:0] cv, span, inc, pc, gain, mag, delta, pdiff;
      sig  = !sample[15] && (sample != 16'd0);
      mode = (mode_q == MODE_PFD || mode_q == MODE_XOR || mode_q == MODE_RS) ? mode_q
                                                                             : MODE_PFD;
      if (use_cv)
         cv = (cv_in > Q_ONE) ? Q_ONE : 64'(cv_in);
      else
         cv = (loop_filter > Q_ONE) ? Q_ONE : 64'(loop_filter);
      span = (max_inc_q > min_inc_q) ? 64'(max_inc_q) - 64'(min_inc_q) : 64'd0;
      inc = 64'(min_inc_q) + ((span * cv + Q_HALF) >> FRAC);
      phase_acc = phase_acc + inc[31:0];
      vco = !phase_acc[31];
      lock = 1'b0;

      case (mode)
         MODE_XOR: begin
            level = (sig != vco) ? LVL_FULL : LVL_ZERO;
         end
         MODE_RS: begin
            r_sig = !rs_sig_d && sig;
            r_vco = !rs_vco_d && vco;
            rs_sig_d = sig;
            rs_vco_d = vco;
            // coincident edges leave the latch alone
            if (r_sig && !r_vco) rs_q = 1'b1;
            if (r_vco && !r_sig) rs_q = 1'b0;
            level = rs_q ? LVL_FULL : LVL_ZERO;
         end
         default: begin
            r_sig = !pfd_sig_d && sig;
            r_vco = !pfd_vco_d && vco;
            pfd_sig_d = sig;
            pfd_vco_d = vco;
            if (r_sig) pfd_sig_q = 1'b1;
            if (r_vco) pfd_vco_q = 1'b1;
            if (pfd_sig_q && pfd_vco_q) begin
               pfd_sig_q = 1'b0;
               pfd_vco_q = 1'b0;
            end
            level = pfd_sig_q ? LVL_FULL : (pfd_vco_q ? LVL_ZERO : LVL_HALF);
         end
      endcase

      // one-pole filter, rounded magnitude applied with the error sign
      pc   = 64'(level) * Q_HALF;
      gain = (gain_q > Q_ONE) ? Q_ONE : 64'(gain_q);
      if (pc >= loop_filter) begin
         mag   = pc - loop_filter;
         delta = (gain * mag + Q_HALF) >> FRAC;
         loop_filter = loop_filter + delta[24:0];
      end else begin
         mag   = loop_filter - pc;
         delta = (gain * mag + Q_HALF) >> FRAC;
         loop_filter = loop_filter - delta[24:0];
      end

      // lock detector is frozen in xor mode
      if (mode != MODE_XOR) begin
         r_sig = !lk_sig_d && sig;
         r_vco = !lk_vco_d && vco;
         lk_sig_d = sig;
         lk_vco_d = vco;
         sig_cnt = (sig_cnt == COUNT_TOP) ? sig_cnt : sig_cnt + 1'b1;
         vco_cnt = (vco_cnt == COUNT_TOP) ? vco_cnt : vco_cnt + 1'b1;
         if (r_sig && sig_cnt > 2) begin
            sig_per = sig_cnt;
            sig_cnt = '0;
         end
         if (r_vco && vco_cnt > 2) begin
            vco_per = vco_cnt;
            vco_cnt = '0;
         end
         if (sig_per != 0 && vco_per != 0) begin
            pdiff = (sig_per > vco_per) ? 64'(sig_per - vco_per) : 64'(vco_per - sig_per);
            lock  = (pdiff * LOCK_RATIO) < 64'(sig_per);
         end
      end

      res.vco_high     = vco;
      res.level        = level;
      res.filter_level = loop_filter;
      res.lock_flag    = lock;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("response %0d: %s is 0x%0h, expected 0x%0h", checked, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      pll_result_type want, got;
      if (reset) begin
         clear_loop_state();
         expected_responses.delete();
         pending = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:    mode_q    = csr_wdata[MODE_W-1:0];
               CSR_MIN_INC: min_inc_q = csr_wdata;
               CSR_MAX_INC: max_inc_q = csr_wdata;
               CSR_GAIN:    gain_q    = csr_wdata[CV_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_pll_step(req_tdata[15:0], req_tdata[40:16], req_tuser, want);
            expected_responses.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.vco_high     = rsp_tdata[0];
            got.level        = rsp_tdata[2:1];
            got.filter_level = rsp_tdata[27:3];
            got.lock_flag    = rsp_tdata[28];
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, '0);
            end else begin
               want = expected_responses.pop_front();
               if (got.vco_high != want.vco_high)
                  report_mismatch("vco_high", 32'(got.vco_high), 32'(want.vco_high));
               if (got.level != want.level)
                  report_mismatch("comparator_level", 32'(got.level), 32'(want.level));
               if (got.filter_level != want.filter_level)
                  report_mismatch("filter_level", 32'(got.filter_level),
                                  32'(want.filter_level));
               if (got.lock_flag != want.lock_flag)
                  report_mismatch("lock_flag", 32'(got.lock_flag), 32'(want.lock_flag));
            end
            checked++;
         end
         pending = expected_responses.size();
      end
   end

endmodule

// File: dv/digital_pll_three_comparators_unit_tb.sv
module digital_pll_three_comparators_unit_tb;
   import dpll_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 165;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [MODE_W-1:0] MODE_PFD_ALIAS = 2'd3;
   localparam logic [24:0] CV_ONE = 25'h1000000;
   localparam logic [24:0] CV_MAX = 25'h1FFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   int sent = 0;
   int taken = 0;
   bit hold_rsp = 1'b0;

   always #10 clock = ~clock;

   digital_pll_three_comparators_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pll_response_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** digital_pll_three_comparators_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] sample, input logic [24:0] cv,
                              input logic use_cv);
      int gap;
      // every 64 requests a run of back-to-back requests
      gap = (sent % 64 < 16) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, cv, sample};
      req_tuser  <= use_cv;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input logic [31:0] min_inc,
                            input logic [31:0] max_inc, input logic [24:0] gain);
      write_reg(CSR_MODE, 32'(mode));
      write_reg(CSR_MIN_INC, min_inc);
      write_reg(CSR_MAX_INC, max_inc);
      write_reg(CSR_GAIN, 32'(gain));
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] high_sample();
      return {1'b0, 15'($urandom_range(1, 32767))};
   endfunction

   function automatic logic [15:0] low_sample();
      return ($urandom_range(0, 3) == 0) ? 16'h0000 : {1'b1, 15'($urandom)};
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = (taken % 50 < 12) ? 0 : $urandom_range(0, 9);
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
         taken++;
      end
   end

   initial begin
      logic [MODE_W-1:0] phase_mode [RANDOM_PHASES];
      logic [31:0]       min_inc, max_inc;
      logic [24:0]       gain;
      logic [15:0]       sample;
      logic              ovr;
      int                n, period, high_len, run_len;
      bit                hold_done;

      phase_mode = '{MODE_PFD, MODE_XOR, MODE_RS, MODE_PFD_ALIAS, MODE_RS};
      hold_done = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, rs comparator
      send_sample(16'h7FFF, 25'd0, 1'b1);
      send_sample(16'h8000, CV_MAX, 1'b1);
      send_sample(16'h0000, CV_ONE, 1'b1);
      send_sample(16'h0001, 25'd0, 1'b0);
      send_sample(16'hFFFF, CV_MAX, 1'b0);
      send_sample(16'h7FFF, 25'h0AAAAAA, 1'b0);
      send_sample(16'h8000, 25'h1555555, 1'b1);
      send_sample(16'h0001, CV_ONE, 1'b0);

      // xor, full increment span, gain above one
      wait_idle();
      configure(MODE_XOR, 32'h0000_0000, 32'hFFFF_FFFF, CV_MAX);
      send_sample(16'h7FFF, CV_ONE, 1'b1);
      send_sample(16'h8000, 25'd0, 1'b1);
      send_sample(16'h0001, CV_MAX, 1'b1);
      send_sample(16'h0000, 25'd0, 1'b0);
      send_sample(16'h7FFF, 25'd0, 1'b0);
      send_sample(16'hFFFF, CV_ONE, 1'b0);

      // vco toggles every sample, aligned with the input: coincident rs edges
      wait_idle();
      configure(MODE_RS, 32'h8000_0000, 32'h8000_0000, CV_ONE);
      for (int i = 0; i < 5; i++)
         send_sample((i % 2) ? 16'h0005 : 16'hFFFB, 25'd0, 1'(i % 2));

      // mode 3, inverted range, zero gain: both pfd flops set together
      wait_idle();
      configure(MODE_PFD_ALIAS, 32'h8000_0000, 32'h0000_0000, 25'd0);
      for (int i = 0; i < 5; i++)
         send_sample((i % 2) ? 16'h0005 : 16'hFFFB, 25'd0, 1'b0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         if (ph == 3) begin
            min_inc = $urandom;
            max_inc = $urandom;
         end else begin
            min_inc = $urandom_range(0, 32'h0080_0000);
            max_inc = $urandom_range(32'h0400_0000, 32'h4000_0000);
         end
         if (ph == 4)
            gain = 25'($urandom_range(32'h0100_0001, 32'h01FF_FFFF));
         else if (ph == 2)
            gain = CV_ONE;
         else
            gain = 25'($urandom_range(1 << 14, 1 << 21));
         configure(phase_mode[ph], min_inc, max_inc, gain);

         n = 0;
         while (n < PHASE_ITEMS) begin
            if (ph == 1 && n >= 30 && !hold_done) begin
               hold_rsp  = 1'b1;
               hold_done = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
               // noise burst
               run_len = $urandom_range(1, 8);
               for (int i = 0; i < run_len && n < PHASE_ITEMS; i++) begin
                  send_sample(16'($urandom), 25'($urandom_range(0, CV_MAX)),
                              1'($urandom_range(0, 1)));
                  n++;
               end
            end else begin
               // square tone the loop can track
               period   = $urandom_range(4, 64);
               high_len = $urandom_range(period / 3, period - period / 3);
               run_len  = $urandom_range(16, 96);
               for (int i = 0; i < run_len && n < PHASE_ITEMS; i++) begin
                  sample = ((i % period) < high_len) ? high_sample() : low_sample();
                  ovr = ($urandom_range(0, 7) == 0);
                  send_sample(sample, ovr ? 25'($urandom_range(0, CV_MAX)) : 25'($urandom),
                              ovr);
                  n++;
               end
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** digital_pll_three_comparators_unit: PASSED **");
      else
         $display("** digital_pll_three_comparators_unit: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
src/dpll_pkg.sv
src/dpll_detect.sv
src/digital_pll_three_comparators_unit.sv
dv/pll_response_checker.sv
dv/digital_pll_three_comparators_unit_tb.sv
